>>> src/u2e_pkg.sv
// shared types, constants and helpers for the utf-8 to unicode escape converter
`default_nettype none

package u2e_pkg;

  // code point width and queue depth
  localparam int unsigned CodeW      = 21;
  localparam int unsigned QueueDepth = 2;

  // byte classes
  localparam logic [7:0] AsciiSpace = 8'd32;
  localparam logic [7:0] AsciiTilde = 8'd126;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharLowerU = 8'h75;

  // one unit of work for the back end: a plain character or an escape
  typedef struct packed {
    logic             is_char;
    logic [CodeW-1:0] value;
    logic             last;
  } job_t;

  // lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/utf8_to_unicode_escape.sv
// top level of the utf-8 to unicode escape converter
// the first character of a byte goes through the queue storage and then the output register
// throughput: one input byte per cycle while the queue has room; one output character per
//   cycle while taken; an escape holds its entry for all its six to eight characters
// the queue between front and back end is the only job buffering; input stalls when it fills
// reset: asynchronous, active low; clears sequence state, queue and output valid
`default_nettype none

module utf8_to_unicode_escape #(
  parameter int unsigned QueueDepth = u2e_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       text_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_out_o,
  output logic            run_end_o,
  output logic            text_end_o
);
  import u2e_pkg::*;

  job_t front_job, back_job;
  logic front_valid, queue_ready, back_valid, back_pop;

  // byte classification
  u2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .text_last_i (text_last_i),
    .job_valid_o (front_valid),
    .job_ready_i (queue_ready),
    .job_o       (front_job)
  );

  // job queue
  u2e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (queue_ready),
    .wr_data_i  (front_job),
    .rd_valid_o (back_valid),
    .rd_pop_i   (back_pop),
    .rd_data_o  (back_job)
  );

  // character expansion
  u2e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_valid),
    .job_pop_o   (back_pop),
    .job_i       (back_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .run_end_o   (run_end_o),
    .text_end_o  (text_end_o)
  );

endmodule

`default_nettype wire

>>> src/u2e_fifo.sv
// small queue of jobs between the front and the back end
`default_nettype none

module u2e_fifo #(
  parameter int unsigned Depth = u2e_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire u2e_pkg::job_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_pop_i,
  output u2e_pkg::job_t      rd_data_o
);
  import u2e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_pop_i & rd_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/u2e_front.sv
// front end: accepts input bytes, tracks utf-8 sequences and issues jobs
`default_nettype none

module u2e_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    byte_in_i,
  input  wire logic          text_last_i,
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output u2e_pkg::job_t      job_o
);
  import u2e_pkg::*;

  logic [1:0]       pend_q, pend_d, pend_dec;
  logic [CodeW-1:0] acc_q, acc_d, acc_cont;
  logic             emit, is_char, accept;
  logic [CodeW-1:0] value;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // continuation bytes shift six bits in; malformed ones add nothing
  assign acc_cont = (byte_in_i[7:6] == 2'b10) ? {acc_q[CodeW-7:0], byte_in_i[5:0]} : acc_q;
  assign pend_dec = pend_q - 2'd1;

  // classify the word and update the sequence state
  always_comb begin
    pend_d  = pend_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    is_char = 1'b0;
    value   = acc_q;
    if (pend_q != 2'd0) begin
      acc_d  = acc_cont;
      pend_d = pend_dec;
      if (pend_dec == 2'd0 || text_last_i) begin
        emit   = 1'b1;
        value  = acc_cont;
        pend_d = 2'd0;
        acc_d  = '0;
      end
    end else if (!byte_in_i[7]) begin
      emit  = 1'b1;
      value = CodeW'(byte_in_i);
      if (byte_in_i >= AsciiSpace && byte_in_i <= AsciiTilde) begin
        is_char = 1'b1;
      end
    end else if (byte_in_i[7:5] == 3'b110) begin
      acc_d  = CodeW'(byte_in_i[4:0]);
      pend_d = 2'd1;
    end else if (byte_in_i[7:4] == 4'b1110) begin
      acc_d  = CodeW'(byte_in_i[3:0]);
      pend_d = 2'd2;
    end else if (byte_in_i[7:3] == 5'b11110) begin
      acc_d  = CodeW'(byte_in_i[2:0]);
      pend_d = 2'd3;
    end else begin
      emit  = 1'b1;
      value = '0;
    end
    // lead byte at end of string flushes the partial point
    if (!emit && text_last_i) begin
      emit  = 1'b1;
      value = acc_d;
    end
    if (text_last_i) begin
      pend_d = 2'd0;
      acc_d  = '0;
    end
  end

  assign job_valid_o   = accept & emit;
  assign job_o.is_char = is_char;
  assign job_o.value   = value;
  assign job_o.last    = text_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

>>> src/u2e_back.sv
// back end: expands jobs into characters, one per cycle while a job waits and output is taken
`default_nettype none

module u2e_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_pop_o,
  input  wire u2e_pkg::job_t job_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         char_out_o,
  output logic               run_end_o,
  output logic               text_end_o
);
  import u2e_pkg::*;

  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q;
  logic [7:0]  char_q;
  logic        run_end_q, text_end_q;
  logic        load, run_end;
  logic [2:0]  ndig, total, pos;
  logic [23:0] padded;
  logic [3:0]  nib;
  logic [7:0]  ch;

  // digit count: four, five or six
  always_comb begin
    if (job_i.value[20]) begin
      ndig = 3'd6;
    end else if (job_i.value[19:16] != 4'd0) begin
      ndig = 3'd5;
    end else begin
      ndig = 3'd4;
    end
  end

  assign total   = job_i.is_char ? 3'd1 : ndig + 3'd2;
  assign run_end = (idx_q == total - 3'd1);
  assign pos     = ndig + 3'd1 - idx_q;
  assign padded  = {3'd0, job_i.value};
  assign nib     = 4'(padded >> {pos, 2'b00});

  // character selection
  always_comb begin
    if (job_i.is_char) begin
      ch = job_i.value[7:0];
    end else if (idx_q == 3'd0) begin
      ch = CharBslash;
    end else if (idx_q == 3'd1) begin
      ch = CharLowerU;
    end else begin
      ch = hex_char(nib);
    end
  end

  assign load      = job_valid_i & (~out_valid_q | out_ready_i);
  assign job_pop_o = load & run_end;
  assign idx_d     = run_end ? 3'd0 : idx_q + 3'd1;

  // output register and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q     <= ch;
      run_end_q  <= run_end;
      text_end_q <= run_end & job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign run_end_o   = run_end_q;
  assign text_end_o  = text_end_q;

endmodule

`default_nettype wire

>>> tb/sv/utf8_to_unicode_escape_tb.sv
// testbench for the utf-8 to unicode escape converter, with a scoreboard class
`timescale 1ns / 1ps

// one expected output character
typedef struct packed {
  logic [7:0] ch;
  logic       run_end;
  logic       text_end;
} esc_char_t;

// predicts the escaped text and checks each output word against it
class escape_scoreboard;
  localparam logic [7:0] BSLASH_CH  = 8'h5c;
  localparam logic [7:0] LOWER_U_CH = 8'h75;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  esc_char_t   exp_chars[$];
  int          n_err;
  int          n_bytes;
  int          n_chars;

  function new();
    cont_left = '0;
    cp_acc    = '0;
    n_err     = 0;
    n_bytes   = 0;
    n_chars   = 0;
  endfunction

  // add one entry at the tail of the expected queue
  function void append_exp(esc_char_t e);
    exp_chars.insert(exp_chars.size(), e);
  endfunction

  function void push_char(logic [7:0] c);
    esc_char_t e;
    e.ch       = c;
    e.run_end  = 1'b0;
    e.text_end = 1'b0;
    append_exp(e);
  endfunction

  // backslash, 'u', then four to six lowercase hex digits
  function void push_escape(logic [20:0] v);
    int         digits;
    logic [3:0] nib;
    digits = 4;
    if (v > 21'hFFFF) digits = 5;
    if (v > 21'hFFFFF) digits = 6;
    push_char(BSLASH_CH);
    push_char(LOWER_U_CH);
    for (int d = digits - 1; d >= 0; d--) begin
      nib = 4'(v >> (4 * d));
      push_char((nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h61 + 8'(nib) - 8'd10));
    end
  endfunction

  // input word accepted: work out the characters it causes
  function void note_byte(logic [7:0] b, logic last);
    int        n0;
    esc_char_t e;
    n0 = exp_chars.size();
    n_bytes++;
    if (cont_left != 2'd0) begin
      // continuation bytes with wrong top bits are swallowed
      if (b[7:6] == 2'b10) cp_acc = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0 || last) begin
        push_escape(cp_acc);
        cont_left = '0;
        cp_acc    = '0;
      end
    end else if (!b[7]) begin
      if (b >= PRINT_LO && b <= PRINT_HI) push_char(b);
      else push_escape({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc    = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc    = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc    = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      push_escape('0);
    end
    // lead byte that ends the string gives its partial point
    if (exp_chars.size() == n0 && last) push_escape(cp_acc);
    if (last) begin
      cont_left = '0;
      cp_acc    = '0;
    end
    if (exp_chars.size() > n0) begin
      e          = exp_chars.pop_back();
      e.run_end  = 1'b1;
      e.text_end = last;
      append_exp(e);
    end
  endfunction

  // output word accepted: compare with the oldest expected character
  function void check_char(logic [7:0] c, logic re, logic te);
    esc_char_t e;
    n_chars++;
    if (exp_chars.size() == 0) begin
      $display("%0t: unexpected char_out=%h run_end=%b text_end=%b", $time, c, re, te);
      n_err++;
      return;
    end
    e = exp_chars.pop_front();
    if (c !== e.ch) begin
      $display("%0t: char_out expected %h actual %h", $time, e.ch, c);
      n_err++;
    end
    if (re !== e.run_end) begin
      $display("%0t: run_end expected %b actual %b", $time, e.run_end, re);
      n_err++;
    end
    if (te !== e.text_end) begin
      $display("%0t: text_end expected %b actual %b", $time, e.text_end, te);
      n_err++;
    end
  endfunction

  function int pending();
    return exp_chars.size();
  endfunction
endclass

module utf8_to_unicode_escape_tb;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int DRAIN_LIMIT = 50000;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in    = 8'd0;
  logic       text_last  = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] char_out;
  logic       run_end;
  logic       text_end;

  int         src_idle_pct  = 0;
  int         snk_stall_pct = 0;
  logic       hold_req      = 1'b0;
  logic       hold_ack      = 1'b0;
  int         hold_left     = 0;
  int         leftover      = 0;
  logic [7:0] stim_bytes[$];

  escape_scoreboard sb;

  utf8_to_unicode_escape uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .byte_in_i   (byte_in),
    .text_last_i (text_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_out_o  (char_out),
    .run_end_o   (run_end),
    .text_end_o  (text_end)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_byte(byte_in, text_last);
      if (out_valid && out_ready) sb.check_char(char_out, run_end, text_end);
    end
  end

  // offer one input word, with an optional idle gap first
  task automatic send_byte(logic [7:0] b, logic last);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    byte_in   <= b;
    text_last <= last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // stop offering and wait for all expected characters
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // add one byte at the tail of the stimulus list
  function automatic void add_stim(logic [7:0] b);
    stim_bytes.insert(stim_bytes.size(), b);
  endfunction

  // append one random character, well formed or not
  task automatic gen_char();
    int         kind;
    int         r;
    int         n_cont;
    int         bad_at;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 28) begin
      add_stim(8'(32 + $urandom_range(94)));
    end else if (kind < 38) begin
      r = $urandom_range(32);
      add_stim((r == 32) ? 8'd127 : 8'(r));
    end else if (kind < 53) begin
      add_stim(8'hC0 | 8'($urandom_range(31)));
      add_stim(cont_byte());
    end else if (kind < 68) begin
      add_stim(8'hE0 | 8'($urandom_range(15)));
      repeat (2) add_stim(cont_byte());
    end else if (kind < 83) begin
      add_stim(8'hF0 | 8'($urandom_range(7)));
      repeat (3) add_stim(cont_byte());
    end else if (kind < 90) begin
      if ($urandom_range(1) == 0) add_stim(8'h80 | 8'($urandom_range(63)));
      else add_stim(8'hF8 | 8'($urandom_range(7)));
    end else begin
      // broken sequence: a bad continuation byte or a short one
      n_cont = $urandom_range(1, 3);
      case (n_cont)
        1: add_stim(8'hC0 | 8'($urandom_range(31)));
        2: add_stim(8'hE0 | 8'($urandom_range(15)));
        default: add_stim(8'hF0 | 8'($urandom_range(7)));
      endcase
      bad_at = $urandom_range(0, n_cont - 1);
      if ($urandom_range(1) == 0) n_cont = $urandom_range(0, n_cont - 1);
      for (int i = 0; i < n_cont; i++) begin
        b = cont_byte();
        if (i == bad_at) begin
          b = 8'($urandom_range(255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
        end
        add_stim(b);
      end
    end
  endtask

  // random text of about n bytes; the last byte closes the string, and about one in ten others do too
  task automatic send_random(int n);
    stim_bytes.delete();
    while (stim_bytes.size() < n) gen_char();
    for (int i = 0; i < stim_bytes.size(); i++) begin
      send_byte(stim_bytes[i], (i == stim_bytes.size() - 1) || ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    logic [8:0] directed[$];
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: {text_last, byte}
    directed = '{
      9'h020, 9'h07e, 9'h000, 9'h07f,          // printable ends, control, delete
      9'h080, 9'h0ff, 9'h0bf, 9'h0f8,          // bad lead bytes
      9'h0c3, 9'h0a9,                          // two-byte point
      9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,          // largest gathered value, six digits
      9'h0f0, 9'h090, 9'h080, 9'h080,          // five digits
      9'h0e2, 9'h041, 9'h0ac,                  // bad continuation byte
      9'h0f0, 9'h190,                          // truncated by end of string
      9'h1c3,                                  // lead byte at end of string
      9'h11f                                   // control char ends the string
    };
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    // random phases with different idle patterns
    src_idle_pct = 0;  snk_stall_pct = 0;  send_random(40); drain();
    src_idle_pct = 53; snk_stall_pct = 0;  send_random(40); drain();
    src_idle_pct = 0;  snk_stall_pct = 53; send_random(40); drain();
    src_idle_pct = 33; snk_stall_pct = 33; send_random(40); drain();

    // long receiver hold-off while the sender keeps pushing escapes
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 30; i++) begin
      send_byte(8'($urandom_range(31)), i == 29);
    end
    drain();

    leftover = sb.pending();
    if (leftover != 0) $display("%0t: %0d expected characters never came", $time, leftover);
    $display("run covered %0d input bytes and %0d output characters", sb.n_bytes, sb.n_chars);
    $display("phases: directed cases, free flow, sender gaps, receiver stalls, mixed, hold-off");
    if (sb.n_err == 0 && leftover == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> utf8_to_unicode_escape.f
src/u2e_pkg.sv
src/u2e_fifo.sv
src/u2e_front.sv
src/u2e_back.sv
src/utf8_to_unicode_escape.sv
tb/sv/utf8_to_unicode_escape_tb.sv
